### rtl/pcwc_pkg.sv
package pcwc_pkg;

   localparam int MAX_SAMPLES   = 131072;
   localparam int SAMPLE_W      = 16;
   localparam int SCALE_W       = 14;
   localparam int QUO_W         = SCALE_W;
   localparam int COUNT_W       = 17;
   localparam int CSR_DATA_W    = 16;

   localparam logic [SAMPLE_W-1:0] TRIGGER_LEVEL_RESET = SAMPLE_W'(39718);
   localparam logic [SCALE_W-1:0]  SCALE_FACTOR_RESET  = SCALE_W'(1000);

   typedef enum logic [0:0] {
      CSR_TRIGGER_LEVEL = 1'b0,
      CSR_SCALE_FACTOR  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                vibration_begins;
      logic                last_sample;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] pulse_count;
      logic [SCALE_W-1:0] high_scaled;
      logic [SCALE_W-1:0] vibration_scaled;
      logic               bad_run;
      logic [COUNT_W-1:0] sample_total;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic mul_load;
      logic mul_vib;
      logic div_start;
      logic store_hs;
      logic store_vs;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic last_in;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

### rtl/pulse_count_window_check_top.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    sample, vibration_begins, last_sample
// rsp_      out        rsp_valid/rsp_ready    pulse_count, high_scaled, vibration_scaled,
//                                             bad_run, sample_total
// csr_      in         csr_we                 csr_index, csr_wdata
//
// A sample beat that is not last is taken in ST_RUN; beats can follow back to back.
// A last beat loads the result register after two multiplies and two passes through the
// shared 14-step divider; the next beat is taken after that load.
// Synchronous active-high reset clears the per-run counters, the controller state and
// the result valid flag and restores register defaults; snapshot and result data are not reset.
// A stalled result holds in the output register; the block waits for it to drain
// only when the next result is ready to load.
module pulse_count_window_check_top #(
   parameter int MAX_SAMPLES = pcwc_pkg::MAX_SAMPLES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pcwc_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pcwc_pkg::rsp_type               rsp_payload,
   input  logic                            csr_we,
   input  pcwc_pkg::csr_index_type         csr_index,
   input  logic [pcwc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pcwc_pkg::cmd_type    cmd;
   pcwc_pkg::status_type status;

   pcwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcwc_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### rtl/pcwc_divider.sv
module pcwc_divider #(
   parameter int IDX_W = 17
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [IDX_W+pcwc_pkg::QUO_W-1:0] dividend,
   input  logic [IDX_W-1:0]               divisor,
   output logic                           done,
   output logic [pcwc_pkg::QUO_W-1:0]     quotient
);

   localparam int QW    = pcwc_pkg::QUO_W;
   localparam int CNT_W = $clog2(QW);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

   logic [IDX_W-1:0] rem_ff;
   logic [IDX_W-1:0] rem_in;
   logic [QW-1:0]    dvd_ff;
   logic [QW-1:0]    q_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [IDX_W:0]   trial;
   logic [IDX_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, dvd_ff[QW-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};
   assign rem_in = ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == LAST_STEP);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[IDX_W+QW-1:QW];
         dvd_ff <= dividend[QW-1:0];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[QW-2:0], 1'b0};
         q_ff   <= {q_ff[QW-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   a_done_timing: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(QW+1) done_ff)
      else $error("divider done pulse out of step with start");

endmodule

### rtl/pcwc_datapath.sv
module pcwc_datapath #(
   parameter int MAX_SAMPLES = pcwc_pkg::MAX_SAMPLES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pcwc_pkg::cmd_type                 cmd,
   output pcwc_pkg::status_type              status,
   input  pcwc_pkg::req_type                 req_payload,
   input  logic                              csr_we,
   input  pcwc_pkg::csr_index_type           csr_index,
   input  logic [pcwc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pcwc_pkg::rsp_type                 rsp_payload
);

   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int QW     = pcwc_pkg::QUO_W;
   localparam int DVD_W  = IDX_W + QW;
   localparam int CNT_W  = pcwc_pkg::COUNT_W;
   localparam int SMP_W  = pcwc_pkg::SAMPLE_W;
   localparam int SCL_W  = pcwc_pkg::SCALE_W;
   localparam logic [IDX_W-1:0] LIMIT = IDX_W'(MAX_SAMPLES - 1);

   logic [SMP_W-1:0] trig_ff;
   logic [SCL_W-1:0] scale_ff;

   logic [IDX_W-1:0] idx_ff;
   logic             prev_ff;
   logic [IDX_W-1:0] edge_cnt_ff;
   logic [IDX_W-1:0] high_ff;
   logic [IDX_W-1:0] vib_ff;
   logic [IDX_W-1:0] first_low_ff;
   logic [IDX_W-1:0] last_low_ff;
   logic             low_seen_ff;

   logic [IDX_W-1:0] t_ff;
   logic [IDX_W-1:0] snap_high_ff;
   logic [IDX_W-1:0] snap_vib_ff;
   logic [IDX_W-1:0] snap_edge_ff;
   logic             bad_ff;
   logic [DVD_W-1:0] prod_ff;
   logic [QW-1:0]    hs_ff;
   logic [QW-1:0]    vs_ff;
   pcwc_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;

   logic             smp_bit;
   logic [IDX_W-1:0] vib_in;
   logic [IDX_W-1:0] edge_cnt_in;
   logic [IDX_W-1:0] idx_inc;
   logic [IDX_W-1:0] high_inc;
   logic [IDX_W+1:0] triple;
   logic [IDX_W-1:0] quarter;
   logic             bad_in;
   logic [IDX_W-1:0] mul_a;
   logic [DVD_W-1:0] prod_in;
   logic [QW-1:0]    quot;
   logic [QW-1:0]    quot_in;
   logic             div_done;

   assign smp_bit     = req_payload.sample >= trig_ff;
   assign vib_in      = req_payload.vibration_begins ? idx_ff : vib_ff;
   assign edge_cnt_in = ((idx_ff != '0) && !prev_ff && smp_bit && (edge_cnt_ff < LIMIT))
                        ? edge_cnt_ff + 1'b1 : edge_cnt_ff;
   assign idx_inc     = (idx_ff < LIMIT) ? idx_ff + 1'b1 : idx_ff;
   assign high_inc    = (high_ff < LIMIT) ? high_ff + 1'b1 : high_ff;
   assign triple      = {2'b00, idx_ff} + {1'b0, idx_ff, 1'b0};
   assign quarter     = triple[IDX_W+1:2];
   assign bad_in      = (low_seen_ff && (first_low_ff <= vib_in))
                     || (low_seen_ff && (last_low_ff >= quarter) && (last_low_ff < idx_ff))
                     || (!smp_bit && (vib_in >= idx_ff));

   assign mul_a   = cmd.mul_vib ? snap_vib_ff : snap_high_ff;
   assign prod_in = DVD_W'(mul_a) * DVD_W'(scale_ff);
   assign quot_in = (t_ff == '0) ? '0 : quot;

   pcwc_divider #(
      .IDX_W (IDX_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (t_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff      <= pcwc_pkg::TRIGGER_LEVEL_RESET;
         scale_ff     <= pcwc_pkg::SCALE_FACTOR_RESET;
         idx_ff       <= '0;
         prev_ff      <= 1'b0;
         edge_cnt_ff  <= '0;
         high_ff      <= '0;
         vib_ff       <= '0;
         first_low_ff <= '0;
         last_low_ff  <= '0;
         low_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               pcwc_pkg::CSR_TRIGGER_LEVEL: trig_ff  <= csr_wdata[SMP_W-1:0];
               pcwc_pkg::CSR_SCALE_FACTOR:  scale_ff <= csr_wdata[SCL_W-1:0];
               default: ;
            endcase
         end
         if (cmd.step) begin
            if (req_payload.last_sample) begin
               idx_ff       <= '0;
               prev_ff      <= 1'b0;
               edge_cnt_ff  <= '0;
               high_ff      <= '0;
               vib_ff       <= '0;
               first_low_ff <= '0;
               last_low_ff  <= '0;
               low_seen_ff  <= 1'b0;
            end else begin
               idx_ff      <= idx_inc;
               prev_ff     <= smp_bit;
               edge_cnt_ff <= edge_cnt_in;
               vib_ff      <= vib_in;
               if (smp_bit) begin
                  high_ff <= high_inc;
               end else begin
                  if (!low_seen_ff) begin
                     first_low_ff <= idx_ff;
                  end
                  last_low_ff <= idx_ff;
                  low_seen_ff <= 1'b1;
               end
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && req_payload.last_sample) begin
         t_ff         <= idx_ff;
         snap_high_ff <= high_ff;
         snap_vib_ff  <= vib_in;
         snap_edge_ff <= edge_cnt_in;
         bad_ff       <= bad_in;
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
      end
      if (cmd.store_hs) begin
         hs_ff <= quot_in;
      end
      if (cmd.store_vs) begin
         vs_ff <= quot_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff.pulse_count      <= CNT_W'(snap_edge_ff);
         rsp_ff.high_scaled      <= hs_ff;
         rsp_ff.vibration_scaled <= vs_ff;
         rsp_ff.bad_run          <= bad_ff;
         rsp_ff.sample_total     <= CNT_W'(t_ff);
      end
   end

   assign status.last_in  = req_payload.last_sample;
   assign status.div_done = div_done;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_high_le_idx: assert property (@(posedge clock) disable iff (reset)
      high_ff <= idx_ff)
      else $error("high count ran past sample index");

   a_low_order: assert property (@(posedge clock) disable iff (reset)
      low_seen_ff |-> (first_low_ff <= last_low_ff))
      else $error("first low index after latest low index");

   a_vib_le_total: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_load |-> (snap_vib_ff <= t_ff) && (snap_high_ff <= t_ff))
      else $error("ratio numerator exceeds run length");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

endmodule

### rtl/pcwc_ctrl.sv
module pcwc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pcwc_pkg::status_type status,
   output pcwc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_RUN,
      ST_MUL_HI,
      ST_START_HI,
      ST_WAIT_HI,
      ST_MUL_VIB,
      ST_START_VIB,
      ST_WAIT_VIB,
      ST_OUTPUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = 1'b1;
               if (status.last_in) begin
                  state_in = ST_MUL_HI;
               end
            end
         end
         ST_MUL_HI: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_START_HI;
         end
         ST_START_HI: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_HI;
         end
         ST_WAIT_HI: begin
            if (status.div_done) begin
               cmd.store_hs = 1'b1;
               state_in     = ST_MUL_VIB;
            end
         end
         ST_MUL_VIB: begin
            cmd.mul_load = 1'b1;
            cmd.mul_vib  = 1'b1;
            state_in     = ST_START_VIB;
         end
         ST_START_VIB: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_VIB;
         end
         ST_WAIT_VIB: begin
            if (status.div_done) begin
               cmd.store_vs = 1'b1;
               state_in     = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
